// ===== hw/rtl/mirror_bit_byte_ring_fifo_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MIRROR_BIT_BYTE_RING_FIFO_CORE_ASSERT_SVH
`define MIRROR_BIT_BYTE_RING_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MBBRF_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MBBRF_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

// ===== hw/rtl/mbbrf_pkg.sv =====
package mbbrf_pkg;

	// Width of the capacity register and of both counts
	localparam int CNT_W = 9;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_FORCE = 2'd1,
		OP_POP   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the word and read the head byte
		logic execute;  // update pointers, write store, load results
	} ctl_cmd_t;

endpackage

// ===== hw/rtl/mirror_bit_byte_ring_fifo_core.sv =====
// Byte ring FIFO with mirror wrap bits. Pulse start with operation (push,
// forced push, pop, clear pointers) and data_in while busy is low; the word
// is taken at that edge. A capture step reads the head byte out of the
// store, then an execute step updates the pointers and writes the store.
// busy is high during the execute step, so a new word cannot be taken
// until the last one is through it. The result is loaded onto the result
// ports by the execute step and marked by done, which is high for a single
// cycle; the receiver cannot stall it and must sample it in that cycle.
// Write capacity_in_use through cfg_wr_en/cfg_wr_data only while idle;
// any write empties the FIFO. A capacity of zero refuses every push and
// pop, and a capacity above the store depth acts as the depth.
module mirror_bit_byte_ring_fifo_core
	import mbbrf_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       operation,
	input  logic [7:0]       data_in,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	output logic             done,
	output logic             accepted,
	output logic [7:0]       data_out,
	output logic             overwrote_oldest,
	output logic [CNT_W-1:0] data_count,
	output logic [CNT_W-1:0] space_count
);

	ctl_cmd_t cmd;

	// Sequence capture and execute cycles
	mbbrf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Hold pointers, mirror bits, capacity and the byte store
	mbbrf_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.operation        (operation),
		.data_in          (data_in),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.done             (done),
		.accepted         (accepted),
		.data_out         (data_out),
		.overwrote_oldest (overwrote_oldest),
		.data_count       (data_count),
		.space_count      (space_count)
	);

endmodule

// ===== hw/rtl/mbbrf_ctrl.sv =====
module mbbrf_ctrl
	import mbbrf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output ctl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign cmd.capture = start && !busy_q;
	assign cmd.execute = (state_q == ST_EXEC);

endmodule

// ===== hw/rtl/mbbrf_dp.sv =====
module mbbrf_dp
	import mbbrf_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_cmd_t         cmd,
	input  logic [1:0]       operation,
	input  logic [7:0]       data_in,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	output logic             done,
	output logic             accepted,
	output logic [7:0]       data_out,
	output logic             overwrote_oldest,
	output logic [CNT_W-1:0] data_count,
	output logic [CNT_W-1:0] space_count
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int WW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [WW-1:0] DEPTH_W = WW'(STORE_DEPTH);

	logic [7:0]       mem [STORE_DEPTH];

	logic [AW-1:0]    rd_pos_q, wr_pos_q;
	logic             rd_wrap_q, wr_wrap_q;
	logic [CNT_W-1:0] cap_q;
	op_t              op_q;
	logic [7:0]       din_q;
	logic [7:0]       rdata_q;
	logic             done_q, acc_q, over_q;
	logic [7:0]       dout_q;
	logic [CNT_W-1:0] cnt_q, space_q;

	logic [WW-1:0]    cap_ext, cap, rd_ext, wr_ext, held, held_nx;
	logic [WW-1:0]    rd_inc, wr_inc;
	logic [AW-1:0]    rd_nx, wr_nx;
	logic             rd_wrap_nx, wr_wrap_nx;
	logic             cap_zero, full, empty;
	logic             do_write, do_pop, do_clear, acc_c, over_c;

	assign cap_ext  = WW'(cap_q);
	assign cap      = (cap_ext > DEPTH_W) ? DEPTH_W : cap_ext;
	assign cap_zero = (cap == '0);
	assign rd_ext   = WW'(rd_pos_q);
	assign wr_ext   = WW'(wr_pos_q);

	always_comb begin
		if (rd_pos_q == wr_pos_q)
			held = (rd_wrap_q == wr_wrap_q) ? '0 : cap;
		else if (wr_pos_q > rd_pos_q)
			held = wr_ext - rd_ext;
		else
			held = cap - rd_ext + wr_ext;
	end

	assign full   = (held >= cap);
	assign empty  = (held == '0);
	assign rd_inc = rd_ext + WW'(1);
	assign wr_inc = wr_ext + WW'(1);

	always_comb begin
		do_write = 1'b0;
		do_pop   = 1'b0;
		do_clear = 1'b0;
		acc_c    = 1'b0;
		over_c   = 1'b0;
		held_nx  = held;
		unique case (op_q)
			OP_PUSH: begin
				if (!cap_zero && !full) begin
					do_write = 1'b1;
					acc_c    = 1'b1;
					held_nx  = held + WW'(1);
				end
			end
			OP_FORCE: begin
				if (!cap_zero) begin
					do_write = 1'b1;
					acc_c    = 1'b1;
					over_c   = full;
					held_nx  = full ? held : held + WW'(1);
				end
			end
			OP_POP: begin
				if (!cap_zero && !empty) begin
					do_pop  = 1'b1;
					acc_c   = 1'b1;
					held_nx = held - WW'(1);
				end
			end
			OP_CLEAR: begin
				do_clear = 1'b1;
				held_nx  = '0;
			end
			default: begin
				held_nx = held;
			end
		endcase
		if (cap_zero)
			held_nx = '0;
	end

	// Wrap to zero and toggle the mirror bit past the last used byte
	always_comb begin
		if (wr_inc >= cap) begin
			wr_nx      = '0;
			wr_wrap_nx = ~wr_wrap_q;
		end else begin
			wr_nx      = wr_inc[AW-1:0];
			wr_wrap_nx = wr_wrap_q;
		end
		if (rd_inc >= cap) begin
			rd_nx      = '0;
			rd_wrap_nx = ~rd_wrap_q;
		end else begin
			rd_nx      = rd_inc[AW-1:0];
			rd_wrap_nx = rd_wrap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q  <= '0;
			wr_pos_q  <= '0;
			rd_wrap_q <= 1'b0;
			wr_wrap_q <= 1'b0;
			cap_q     <= CNT_W'(256);
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cfg_wr_en) begin
				cap_q     <= cfg_wr_data;
				rd_pos_q  <= '0;
				wr_pos_q  <= '0;
				rd_wrap_q <= 1'b0;
				wr_wrap_q <= 1'b0;
			end else if (cmd.execute) begin
				if (do_clear) begin
					rd_pos_q  <= '0;
					wr_pos_q  <= '0;
					rd_wrap_q <= 1'b0;
					wr_wrap_q <= 1'b0;
				end else begin
					if (do_write) begin
						wr_pos_q  <= wr_nx;
						wr_wrap_q <= wr_wrap_nx;
					end
					if (do_pop || over_c) begin
						rd_pos_q  <= rd_nx;
						rd_wrap_q <= rd_wrap_nx;
					end
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(operation);
			din_q   <= data_in;
			rdata_q <= mem[rd_pos_q];
		end
		if (cmd.execute) begin
			acc_q   <= acc_c;
			over_q  <= over_c;
			dout_q  <= do_pop ? rdata_q : 8'd0;
			cnt_q   <= held_nx[CNT_W-1:0];
			space_q <= CNT_W'(cap - held_nx);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && do_write)
			mem[wr_pos_q] <= din_q;
	end

	assign done             = done_q;
	assign accepted         = acc_q;
	assign data_out         = dout_q;
	assign overwrote_oldest = over_q;
	assign data_count       = cnt_q;
	assign space_count      = space_q;

endmodule

// ===== hw/rtl/mbbrf_chk.sv =====
`include "mirror_bit_byte_ring_fifo_core_assert.svh"

module mbbrf_chk
	import mbbrf_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             accepted,
	input logic [7:0]       data_out,
	input logic             overwrote_oldest,
	input logic [CNT_W-1:0] space_count
);

	`MBBRF_ASSERT_NOW(a_result_latency, start && !busy, ##2 done, "result missing after word")
	`MBBRF_ASSERT_NEXT(a_busy_one_cycle, busy, !busy, "busy held too long")
	`MBBRF_ASSERT_NOW(a_refused_quiet, done && !accepted, data_out == 8'd0 && !overwrote_oldest, "refused word carries data")
	`MBBRF_ASSERT_NOW(a_overwrite_full, done && overwrote_oldest, accepted && space_count == '0, "overwrite while not full")

endmodule

bind mirror_bit_byte_ring_fifo_core mbbrf_chk u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.accepted         (accepted),
	.data_out         (data_out),
	.overwrote_oldest (overwrote_oldest),
	.space_count      (space_count)
);
